// File: sv/plle_pkg.sv
// Package: sizes, command codes, status codes and beat structs of the list engine.
package plle_pkg;

    localparam int Capacity   = 256;
    localparam int LinkWidth  = $clog2(Capacity) + 1;
    localparam int AddrWidth  = $clog2(Capacity);
    localparam int DataWidth  = 32;

    typedef logic [LinkWidth-1:0] link_t;
    typedef logic [AddrWidth-1:0] addr_t;

    localparam link_t NIL = link_t'(Capacity);

    typedef enum logic [3:0] {
        CMD_NEXT       = 4'd0,
        CMD_PREV       = 4'd1,
        CMD_READ       = 4'd2,
        CMD_FRONT      = 4'd3,
        CMD_REAR       = 4'd4,
        CMD_INS_CUR    = 4'd5,
        CMD_INS_FRONT  = 4'd6,
        CMD_INS_REAR   = 4'd7,
        CMD_ERA_CUR    = 4'd8,
        CMD_ERA_FRONT  = 4'd9,
        CMD_ERA_REAR   = 4'd10,
        CMD_CLEAR      = 4'd11,
        CMD_READ_IDX   = 4'd12,
        CMD_CUR_IDX    = 4'd13
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] value;
        logic [7:0]         index;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [8:0]         position;
        logic [8:0]         count;
        logic               is_empty;
        logic [1:0]         status;
    } out_beat_t;

endpackage

// File: sv/positional_linked_list_engine_unit.sv
// Top level: linked list engine with node pool in synchronous memories.
//
// Usage: one command beat on s_ (s_valid/s_ready, payload s_data) yields
// exactly one result beat on m_ (m_valid/m_ready, payload m_data).
// Node values with next links share one memory, previous links sit in a
// second; both are read synchronously into output registers. A sequencer
// issues reads from its states and writes the modified links back.
// A command runs from decode through its memory reads and link write-backs
// to the result state. To front, to rear, clear, unused codes, next or prev
// with the cursor at the rear and every command refused at decode (full
// pool, nothing to erase or read, index out of range) go straight from
// decode to the result state. Read by index and cursor index walk the list
// from the front, one node read at a time.
// Only one command is in flight: the next beat is accepted only once the
// result has been loaded into the output register.
// Reset (aresetn low, synchronous) empties the list, puts the cursor at the
// rear and empties the free list; memory contents are not cleared, and a
// value read from an unwritten entry is never used.
// When the receiver stalls, the result is held in m_data; the following
// command is still accepted and runs up to its result, then waits there.
module positional_linked_list_engine_unit
    import plle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    typedef enum logic [3:0] {
        IDLE, DECODE, RD1, RD1W, INS_W, ERA_W, ERA_W2, WALK, WALKW, DONE
    } state_t;

    typedef struct packed {
        logic [DataWidth-1:0] value;
        link_t                nxt;
    } node_t;

    state_t state_reg;
    in_beat_t cmd_reg;

    // Pool memories: value with next link, and previous link.
    node_t node_mem [Capacity];
    link_t prv_mem [Capacity];

    logic                 rd_en;
    addr_t                rd_addr;
    logic [DataWidth-1:0] val_q;
    link_t                nxt_q, prv_q;

    logic  nw_en, pw_en, vw_en;
    addr_t nw_addr, pw_addr;
    link_t nw_data, pw_data;
    logic [DataWidth-1:0] vw_data;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            val_q <= node_mem[rd_addr].value;
            nxt_q <= node_mem[rd_addr].nxt;
            prv_q <= prv_mem[rd_addr];
        end
        if (nw_en) begin
            node_mem[nw_addr].nxt <= nw_data;
            if (vw_en) node_mem[nw_addr].value <= vw_data;
        end
        if (pw_en) prv_mem[pw_addr] <= pw_data;
    end

    // Control registers.
    link_t first_reg, last_reg, cur_reg, free_reg, fresh_reg, cnt_reg;
    link_t node_reg;     // target node / walker
    link_t newn_reg;     // node taken for insert
    link_t bef_reg, aft_reg;
    logic [8:0] walk_reg;
    logic [DataWidth-1:0] dat_reg;
    logic [1:0] st_reg;
    logic [8:0] pos_reg;

    logic out_full;
    logic res_load;
    assign m_valid  = out_full;
    assign s_ready  = (state_reg == IDLE);
    // Load the output register once it is free or being emptied.
    assign res_load = (state_reg == DONE) && (!out_full || m_ready);

    function automatic logic is_node(link_t l);
        return !l[LinkWidth-1];
    endfunction

    always_comb begin
        rd_en = 1'b0; rd_addr = '0;
        nw_en = 1'b0; nw_addr = '0; nw_data = '0;
        pw_en = 1'b0; pw_addr = '0; pw_data = '0;
        vw_en = 1'b0; vw_data = '0;
        case (state_reg)
            DECODE: begin
                case (cmd_t'(cmd_reg.cmd))
                    CMD_NEXT, CMD_PREV, CMD_READ, CMD_ERA_CUR: begin
                        rd_en = 1'b1; rd_addr = cur_reg[AddrWidth-1:0];
                    end
                    CMD_ERA_FRONT: begin
                        rd_en = 1'b1; rd_addr = first_reg[AddrWidth-1:0];
                    end
                    CMD_ERA_REAR: begin
                        rd_en = 1'b1; rd_addr = last_reg[AddrWidth-1:0];
                    end
                    CMD_INS_CUR: begin
                        // Cursor at the rear: go straight to the free head.
                        rd_en = 1'b1;
                        rd_addr = is_node(cur_reg) ? cur_reg[AddrWidth-1:0]
                                                   : free_reg[AddrWidth-1:0];
                    end
                    CMD_INS_FRONT, CMD_INS_REAR: begin
                        rd_en = 1'b1; rd_addr = free_reg[AddrWidth-1:0];
                    end
                    default: ;
                endcase
            end
            RD1: begin
                // Second read: free head for insert at cursor.
                rd_en = 1'b1; rd_addr = free_reg[AddrWidth-1:0];
            end
            INS_W: begin
                vw_en = 1'b1;
                vw_data = cmd_reg.value;
                nw_en = 1'b1; nw_addr = newn_reg[AddrWidth-1:0]; nw_data = aft_reg;
                pw_en = 1'b1; pw_addr = newn_reg[AddrWidth-1:0]; pw_data = bef_reg;
            end
            ERA_W: begin
                if (is_node(bef_reg)) begin
                    nw_en = 1'b1; nw_addr = bef_reg[AddrWidth-1:0]; nw_data = aft_reg;
                end
                if (is_node(aft_reg)) begin
                    pw_en = 1'b1; pw_addr = aft_reg[AddrWidth-1:0]; pw_data = bef_reg;
                end
            end
            ERA_W2: begin
                nw_en = 1'b1; nw_addr = node_reg[AddrWidth-1:0]; nw_data = free_reg;
            end
            WALK: begin
                rd_en = 1'b1; rd_addr = node_reg[AddrWidth-1:0];
            end
            DONE: begin
                // Insert: relink the neighbours.
                if (cmd_reg.cmd == CMD_INS_CUR || cmd_reg.cmd == CMD_INS_FRONT
                        || cmd_reg.cmd == CMD_INS_REAR) begin
                    if (st_reg == ST_OK) begin
                        if (is_node(bef_reg)) begin
                            nw_en = 1'b1; nw_addr = bef_reg[AddrWidth-1:0];
                            nw_data = newn_reg;
                        end
                        if (is_node(aft_reg)) begin
                            pw_en = 1'b1; pw_addr = aft_reg[AddrWidth-1:0];
                            pw_data = newn_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            out_full  <= 1'b0;
            first_reg <= NIL; last_reg <= NIL; cur_reg <= NIL;
            free_reg  <= NIL; fresh_reg <= '0; cnt_reg <= '0;
        end else begin
            out_full <= res_load || (out_full && !m_ready);
            case (state_reg)
                IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg   <= s_data;
                        dat_reg   <= '0;
                        st_reg    <= ST_OK;
                        pos_reg   <= '0;
                        state_reg <= DECODE;
                    end
                end
                DECODE: begin
                    case (cmd_t'(cmd_reg.cmd))
                        CMD_NEXT, CMD_PREV, CMD_READ: begin
                            if (is_node(cur_reg)) begin
                                state_reg <= RD1W;
                            end else begin
                                state_reg <= DONE;
                                if (cmd_reg.cmd == CMD_PREV && is_node(last_reg))
                                    cur_reg <= last_reg;
                                if (cmd_reg.cmd == CMD_READ) st_reg <= ST_EMPTY;
                            end
                        end
                        CMD_FRONT: begin
                            cur_reg   <= first_reg;
                            state_reg <= DONE;
                        end
                        CMD_REAR: begin
                            cur_reg   <= NIL;
                            state_reg <= DONE;
                        end
                        CMD_INS_CUR, CMD_INS_FRONT, CMD_INS_REAR: begin
                            aft_reg <= (cmd_reg.cmd == CMD_INS_CUR) ? cur_reg :
                                       (cmd_reg.cmd == CMD_INS_FRONT) ? first_reg : NIL;
                            if (cnt_reg >= link_t'(Capacity) ||
                                    (!is_node(free_reg) && !is_node(fresh_reg))) begin
                                st_reg    <= ST_FULL;
                                state_reg <= DONE;
                            end else if (cmd_reg.cmd == CMD_INS_CUR && is_node(cur_reg))
                                state_reg <= RD1;
                            else begin
                                bef_reg <= (cmd_reg.cmd == CMD_INS_FRONT) ? NIL : last_reg;
                                state_reg <= RD1W;
                            end
                        end
                        CMD_ERA_CUR, CMD_ERA_FRONT, CMD_ERA_REAR: begin
                            node_reg <= (cmd_reg.cmd == CMD_ERA_CUR) ? cur_reg :
                                        (cmd_reg.cmd == CMD_ERA_FRONT) ? first_reg : last_reg;
                            if ((cmd_reg.cmd == CMD_ERA_CUR && !is_node(cur_reg)) ||
                                    (cmd_reg.cmd == CMD_ERA_FRONT && !is_node(first_reg)) ||
                                    (cmd_reg.cmd == CMD_ERA_REAR && !is_node(last_reg))) begin
                                st_reg    <= ST_EMPTY;
                                state_reg <= DONE;
                            end else state_reg <= RD1W;
                        end
                        CMD_CLEAR: begin
                            first_reg <= NIL; last_reg <= NIL; cur_reg <= NIL;
                            free_reg <= NIL; fresh_reg <= '0; cnt_reg <= '0;
                            state_reg <= DONE;
                        end
                        CMD_READ_IDX: begin
                            if ({1'b0, cmd_reg.index} >= cnt_reg) begin
                                st_reg    <= ST_RANGE;
                                state_reg <= DONE;
                            end else begin
                                node_reg <= first_reg; walk_reg <= '0;
                                state_reg <= WALK;
                            end
                        end
                        CMD_CUR_IDX: begin
                            node_reg <= first_reg; walk_reg <= '0;
                            state_reg <= WALK;
                        end
                        default: state_reg <= DONE;
                    endcase
                end
                RD1: begin
                    // Cursor node read issued in DECODE: capture its prev.
                    bef_reg   <= prv_q;
                    state_reg <= RD1W;
                end
                RD1W: begin
                    case (cmd_t'(cmd_reg.cmd))
                        CMD_NEXT: begin
                            cur_reg   <= nxt_q;
                            state_reg <= DONE;
                        end
                        CMD_PREV: begin
                            if (is_node(prv_q)) cur_reg <= prv_q;
                            state_reg <= DONE;
                        end
                        CMD_READ: begin
                            dat_reg   <= val_q;
                            state_reg <= DONE;
                        end
                        CMD_INS_CUR, CMD_INS_FRONT, CMD_INS_REAR: begin
                            // nxt_q holds the free head's next link here.
                            if (cmd_reg.cmd == CMD_INS_FRONT) bef_reg <= NIL;
                            else if (!is_node(aft_reg)) bef_reg <= last_reg;
                            if (is_node(free_reg)) begin
                                newn_reg <= free_reg;
                                free_reg <= nxt_q;
                            end else begin
                                newn_reg  <= fresh_reg;
                                fresh_reg <= fresh_reg + 1'b1;
                            end
                            state_reg <= INS_W;
                        end
                        default: begin
                            dat_reg <= val_q;
                            bef_reg <= prv_q;
                            aft_reg <= nxt_q;
                            state_reg <= ERA_W;
                        end
                    endcase
                end
                INS_W: begin
                    if (!is_node(bef_reg)) first_reg <= newn_reg;
                    if (!is_node(aft_reg)) last_reg <= newn_reg;
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= DONE;
                end
                ERA_W: begin
                    if (!is_node(bef_reg)) first_reg <= aft_reg;
                    if (!is_node(aft_reg)) last_reg <= bef_reg;
                    if (cur_reg == node_reg) cur_reg <= aft_reg;
                    state_reg <= ERA_W2;
                end
                ERA_W2: begin
                    free_reg  <= node_reg;
                    if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
                    state_reg <= DONE;
                end
                WALK: begin
                    // Stop conditions checked in the state that issues the next read.
                    if (cmd_reg.cmd == CMD_CUR_IDX &&
                            (node_reg == cur_reg || !is_node(node_reg))) begin
                        pos_reg   <= walk_reg;
                        state_reg <= DONE;
                    end else if (cmd_reg.cmd == CMD_READ_IDX &&
                            !is_node(node_reg)) begin
                        st_reg    <= ST_RANGE;
                        state_reg <= DONE;
                    end else state_reg <= WALKW;
                end
                WALKW: begin
                    if (cmd_reg.cmd == CMD_READ_IDX && walk_reg == {1'b0, cmd_reg.index}) begin
                        dat_reg   <= val_q;
                        state_reg <= DONE;
                    end else begin
                        node_reg  <= nxt_q;
                        walk_reg  <= walk_reg + 1'b1;
                        state_reg <= WALK;
                    end
                end
                DONE: begin
                    if (res_load) begin
                        m_data.data     <= dat_reg;
                        m_data.position <= pos_reg;
                        m_data.count    <= cnt_reg;
                        m_data.is_empty <= (cnt_reg == '0);
                        m_data.status   <= st_reg;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // Hold a stalled result beat unchanged.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped while stalled");
    // Count never exceeds the pool.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= link_t'(Capacity)) else $error("count overflow");
    // Empty flag agrees with count.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.count == '0))) else $error("empty flag");

endmodule

// File: tb/positional_linked_list_engine_unit_tb.sv
// Testbench: list engine driven with directed and random commands, checked against a list model.
module positional_linked_list_engine_unit_tb
    import plle_pkg::*;
();

    // Scoreboard: keeps its own copy of the list and a queue of expected result beats.
    class list_scoreboard;
        logic [31:0] vals [Capacity];
        link_t       nxt  [Capacity];
        link_t       prv  [Capacity];
        link_t       head, tail, cur, free_top, fresh;
        int          size;
        out_beat_t   pending [$];
        int          errors;
        int          results_seen;

        function void clear_list();
            head = NIL; tail = NIL; cur = NIL;
            free_top = NIL; fresh = '0; size = 0;
        endfunction

        function bit link_before(link_t pos, logic [31:0] v);
            link_t n, b;
            if (size >= Capacity) return 0;
            if (free_top != NIL) begin
                n = free_top;
                free_top = nxt[n[AddrWidth-1:0]];
            end else begin
                if (fresh == NIL) return 0;
                n = fresh;
                fresh = fresh + 1'b1;
            end
            b = (pos != NIL) ? prv[pos[AddrWidth-1:0]] : tail;
            vals[n[AddrWidth-1:0]] = v;
            nxt[n[AddrWidth-1:0]] = pos;
            prv[n[AddrWidth-1:0]] = b;
            if (b != NIL) nxt[b[AddrWidth-1:0]] = n;
            else head = n;
            if (pos != NIL) prv[pos[AddrWidth-1:0]] = n;
            else tail = n;
            size++;
            return 1;
        endfunction

        function logic [31:0] unlink(link_t n);
            link_t b, a;
            b = prv[n[AddrWidth-1:0]];
            a = nxt[n[AddrWidth-1:0]];
            if (b != NIL) nxt[b[AddrWidth-1:0]] = a;
            else head = a;
            if (a != NIL) prv[a[AddrWidth-1:0]] = b;
            else tail = b;
            if (cur == n) cur = a;
            nxt[n[AddrWidth-1:0]] = free_top;
            free_top = n;
            if (size > 0) size--;
            return vals[n[AddrWidth-1:0]];
        endfunction

        // Apply one accepted command and queue the beat it should produce.
        function void note_command(in_beat_t c);
            out_beat_t r;
            link_t     n;
            int        i;
            r = '0;
            case (c.cmd)
                CMD_NEXT: if (cur != NIL) cur = nxt[cur[AddrWidth-1:0]];
                CMD_PREV: begin
                    if (cur != NIL) begin
                        if (prv[cur[AddrWidth-1:0]] != NIL) cur = prv[cur[AddrWidth-1:0]];
                    end else if (tail != NIL) cur = tail;
                end
                CMD_READ: begin
                    if (cur != NIL) r.data = vals[cur[AddrWidth-1:0]];
                    else r.status = ST_EMPTY;
                end
                CMD_FRONT: cur = head;
                CMD_REAR: cur = NIL;
                CMD_INS_CUR, CMD_INS_FRONT, CMD_INS_REAR: begin
                    n = (c.cmd == CMD_INS_CUR) ? cur : (c.cmd == CMD_INS_FRONT) ? head : NIL;
                    if (!link_before(n, c.value)) r.status = ST_FULL;
                end
                CMD_ERA_CUR, CMD_ERA_FRONT, CMD_ERA_REAR: begin
                    n = (c.cmd == CMD_ERA_CUR) ? cur : (c.cmd == CMD_ERA_FRONT) ? head : tail;
                    if (n != NIL) r.data = unlink(n);
                    else r.status = ST_EMPTY;
                end
                CMD_CLEAR: clear_list();
                CMD_READ_IDX: begin
                    if (c.index >= size) r.status = ST_RANGE;
                    else begin
                        n = head;
                        for (i = 0; i < c.index && n != NIL; i++) n = nxt[n[AddrWidth-1:0]];
                        if (n != NIL) r.data = vals[n[AddrWidth-1:0]];
                        else r.status = ST_RANGE;
                    end
                end
                CMD_CUR_IDX: begin
                    n = head;
                    i = 0;
                    while (n != cur && n != NIL && i < Capacity) begin
                        n = nxt[n[AddrWidth-1:0]];
                        i++;
                    end
                    r.position = 9'(i);
                end
                default: ;
            endcase
            r.count = 9'(size);
            r.is_empty = (size == 0);
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            results_seen++;
            if (pending.size() == 0) begin
                $display("unexpected result beat %0h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.data !== want.data) report("data", got.data, want.data);
            if (got.position !== want.position) report("position", got.position, want.position);
            if (got.count !== want.count) report("count", got.count, want.count);
            if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
            if (got.status !== want.status) report("status", got.status, want.status);
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    list_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycles;
    int  sent;

    positional_linked_list_engine_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: worst case is a full walk per item with long stalls on both sides.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 5000000) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Sample result beats at the rising edge; pick the receiver's stall at the falling edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one command beat; hold it until accepted, idling beforehand at random.
    task automatic send_command(cmd_t c, logic [31:0] v, int idx);
        in_beat_t b;
        b.cmd = c;
        b.value = v;
        b.index = 8'(idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(b);
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Random commands: inserts dominate so the list grows deep, with erases and walks mixed in.
    task automatic random_phase(int items, int grow);
        int k, r;
        cmd_t c;
        for (k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < grow) c = cmd_t'(CMD_INS_CUR + $urandom_range(2));
            else if (r < grow + 20) c = cmd_t'(CMD_ERA_CUR + $urandom_range(2));
            else if (r < 98) c = cmd_t'($urandom_range(CMD_CUR_IDX));
            else c = ($urandom_range(1) != 0) ? CMD_CLEAR : cmd_t'(4'd14 + $urandom_range(1));
            send_command(c, pick_value(), 8'($urandom));
        end
    endtask

    initial begin
        int k, j;
        board = new();
        board.clear_list();
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        sent = 0;
        send_idle_pct = 29;
        recv_idle_pct = 88;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-list errors, ends of the cursor, value extremes, every command except to rear.
        send_command(CMD_READ, 0, 0);
        send_command(CMD_ERA_CUR, 0, 0);
        send_command(CMD_ERA_FRONT, 0, 0);
        send_command(CMD_ERA_REAR, 0, 0);
        send_command(CMD_PREV, 0, 0);
        send_command(CMD_NEXT, 0, 0);
        send_command(CMD_READ_IDX, 0, 8'd0);
        send_command(CMD_INS_REAR, 32'h7fff_ffff, 0);
        send_command(CMD_INS_FRONT, 32'h8000_0000, 0);
        send_command(CMD_FRONT, 0, 0);
        send_command(CMD_PREV, 0, 0);
        send_command(CMD_INS_CUR, 32'hffff_ffff, 0);
        send_command(CMD_CUR_IDX, 0, 0);
        send_command(CMD_NEXT, 0, 0);
        send_command(CMD_NEXT, 0, 0);
        send_command(CMD_NEXT, 0, 0);
        send_command(CMD_CUR_IDX, 0, 0);
        send_command(CMD_PREV, 0, 0);
        send_command(CMD_READ, 0, 0);
        send_command(CMD_ERA_CUR, 0, 0);
        send_command(CMD_READ_IDX, 0, 8'd1);
        send_command(CMD_READ_IDX, 0, 8'd255);
        send_command(cmd_t'(4'd15), 0, 0);
        send_command(CMD_CLEAR, 0, 0);

        // Fill and overflow the pool, walk to the far end, erase from the front, refill, clear.
        for (k = 0; k < Capacity; k++) send_command(CMD_INS_REAR, $urandom, 8'd0);
        send_command(CMD_INS_FRONT, 32'h1234_5678, 0);
        send_command(CMD_READ_IDX, 0, 8'd255);
        send_command(CMD_CUR_IDX, 0, 0);
        send_command(CMD_PREV, 0, 0);
        send_command(CMD_CUR_IDX, 0, 0);
        for (k = 0; k < 120; k++) send_command(CMD_ERA_FRONT, 0, 0);
        for (k = 0; k < 40; k++) send_command(CMD_INS_CUR, $urandom, 0);
        send_command(CMD_CLEAR, 0, 0);

        // Random part in three idling regimes.
        for (j = 0; j < 3; j++) begin
            if (j == 1) begin send_idle_pct = 88; recv_idle_pct = 29; end
            if (j == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            random_phase(220, (j == 1) ? 50 : 40);
        end
        s_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("%0d commands sent, %0d result beats checked, including a full pool",
                 sent, board.results_seen);
        $display("covered every command, overflow, empty erases and walks of up to 256 nodes");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
